FILE: hdl/fpfa_pkg.sv
// fpfa_pkg: sizes, operation codes and field widths for the partition allocator
// used by fixed_partition_fit_allocator; depends on nothing else
package fpfa_pkg;

  localparam int MAX_PARTITIONS = 16;
  localparam int SIZE_BITS      = 16;

  // block_index and granted_index cover sixteen partitions
  localparam int INDEX_SPAN = 16;
  localparam int SPAN       = (MAX_PARTITIONS < INDEX_SPAN) ? MAX_PARTITIONS : INDEX_SPAN;

  localparam int IDX_W  = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int SPAN_W = (SPAN > 1) ? $clog2(SPAN) : 1;
  localparam int CNT_W  = $clog2(SPAN + 1);

  localparam int OP_W     = 2;
  localparam int BIDX_W   = 4;
  localparam int AMOUNT_W = 16;
  localparam int ACTIVE_W = 5;
  localparam int GIDX_W   = 4;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_FIRST = 2'd1,
    OP_BEST  = 2'd2
  } op_t;

endpackage

FILE: hdl/fixed_partition_fit_allocator.sv
// fixed_partition_fit_allocator: partition table with first fit and best fit search
// depends on fpfa_pkg for sizes and operation codes
//
// Usage
//   s_axis carries one word per item: tuser is the op, tdata holds block_index
//   and amount. A load (op 0) writes a partition size into the size memory and
//   frees that partition; it returns nothing. A first fit
//   (op 1) or best fit (op 2) request scans the active partitions one per cycle
//   through the size memory and returns one word on m_axis with found and
//   granted_index. Op 3 is dropped.
//   A request reads the size memory once per partition up to limit, where
//   limit is active_blocks capped at the table depth, then takes one trailing
//   compare and one update step before m_axis_tvalid. One item is worked on at
//   a time: the next word is taken only once the block is idle again.
//   s_axis_tready is high only while idle, also while a result still waits in
//   the output register.
//   cfg writes active_blocks and is always ready; write it only while idle.
//   Reset clears all allocated marks and active_blocks; the size memory is not
//   cleared, a partition must be loaded before it is searched.
//   While m_axis_tready is low the finished result holds in the output register
//   and the next request waits at its final step.
module fixed_partition_fit_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [3:0] block_index, [19:4] amount, [23:20] zero
  input  logic [fpfa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] op
  input  logic [fpfa_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] found, [4:1] granted_index, [7:5] zero
  output logic [fpfa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fpfa_pkg::ACTIVE_W-1:0]   cfg_data
);
  import fpfa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t state;
  logic [ACTIVE_W-1:0]       active_blocks;
  logic [MAX_PARTITIONS-1:0] taken;
  logic [SIZE_BITS-1:0]      size_mem [MAX_PARTITIONS];
  logic [SIZE_BITS-1:0]      rd_data;

  op_t                 op_q;
  logic [SIZE_BITS-1:0] amt_q;
  logic [CNT_W-1:0]     lim_q;
  logic [CNT_W-1:0]     issue_cnt;
  logic                 cmp_valid;
  logic [SPAN_W-1:0]    cmp_idx;
  logic                 have;
  logic [SPAN_W-1:0]    pick;
  logic [SIZE_BITS-1:0] best_size;
  logic                 found;
  logic [GIDX_W-1:0]    granted_index;

  logic [BIDX_W-1:0]         in_bidx;
  logic [AMOUNT_W-1:0]       in_amount;
  logic [AMOUNT_W+SIZE_BITS-1:0] amt_wide;
  logic [SIZE_BITS-1:0]      in_amt;
  logic [IDX_W+BIDX_W-1:0]   bidx_wide;
  logic [IDX_W-1:0]          load_addr;
  logic                      load_ok;
  logic [CNT_W-1:0]          lim_in;
  logic                      in_fire;
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;
  logic [IDX_W-1:0]          cmp_addr;
  logic [IDX_W-1:0]          pick_addr;
  logic                      fit;
  logic                      better;
  logic                      out_free;

  assign in_bidx   = s_axis_tdata[BIDX_W-1:0];
  assign in_amount = s_axis_tdata[BIDX_W+AMOUNT_W-1:BIDX_W];
  // amount reduced or widened to the stored size width
  assign amt_wide  = {{SIZE_BITS{1'b0}}, in_amount};
  assign in_amt    = amt_wide[SIZE_BITS-1:0];
  assign bidx_wide = {{IDX_W{1'b0}}, in_bidx};
  assign load_addr = bidx_wide[IDX_W-1:0];
  assign load_ok   = (32'(in_bidx) < MAX_PARTITIONS);
  assign lim_in    = (32'(active_blocks) > SPAN) ? CNT_W'(SPAN)
                                                 : CNT_W'(active_blocks);

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign rd_en     = (state == S_SCAN) && (issue_cnt < lim_q);
  assign rd_addr   = IDX_W'(issue_cnt[SPAN_W-1:0]);
  assign cmp_addr  = IDX_W'(cmp_idx);
  assign pick_addr = IDX_W'(pick);

  assign fit    = cmp_valid && !taken[cmp_addr] && (rd_data >= amt_q);
  assign better = (op_q == OP_FIRST) ? !have : (!have || rd_data < best_size);

  assign m_axis_tdata = {{(OUT_DATA_W - 1 - GIDX_W){1'b0}}, granted_index, found};

  // size memory: one write port for loads, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (in_fire && op_t'(s_axis_tuser) == OP_LOAD && load_ok) begin
      size_mem[load_addr] <= in_amt;
    end
    if (rd_en) begin
      rd_data <= size_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_blocks <= '0;
    end else if (cfg_valid && cfg_ready) begin
      active_blocks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      taken         <= '0;
      m_axis_tvalid <= 1'b0;
      cmp_valid     <= 1'b0;
      issue_cnt     <= '0;
      have          <= 1'b0;
      op_q          <= OP_FIRST;
      amt_q         <= '0;
      lim_q         <= '0;
      cmp_idx       <= '0;
      pick          <= '0;
      best_size     <= '0;
      found         <= 1'b0;
      granted_index <= '0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (op_t'(s_axis_tuser))
              OP_LOAD: begin
                if (load_ok) begin
                  taken[load_addr] <= 1'b0;
                end
              end
              OP_FIRST, OP_BEST: begin
                op_q      <= op_t'(s_axis_tuser);
                amt_q     <= in_amt;
                lim_q     <= lim_in;
                issue_cnt <= '0;
                cmp_valid <= 1'b0;
                have      <= 1'b0;
                pick      <= '0;
                state     <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // issue one read, compare the previous read
          if (rd_en) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          cmp_valid <= rd_en;
          cmp_idx   <= issue_cnt[SPAN_W-1:0];
          if (fit && better) begin
            have      <= 1'b1;
            pick      <= cmp_idx;
            best_size <= rd_data;
          end
          if (!rd_en && !cmp_valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            found         <= have;
            granted_index <= have ? GIDX_W'(pick) : '0;
            if (have) begin
              taken[pick_addr] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_grant_marks: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free && have) |=> taken[$past(pick_addr)])
    else $error("granted partition not marked allocated");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (CNT_W'(cmp_idx) < lim_q))
    else $error("scan compared a partition beyond the search limit");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!cmp_valid && !rd_en))
    else $error("scan activity while idle");

  a_nofound_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free && !have) |=> (m_axis_tvalid && granted_index == '0))
    else $error("failed request reports a nonzero index");

endmodule
